>>> hw/rtl/lmlt_pkg.sv
// Package for the LCD mode/line timing core: video mode codes, timing
// constants and configuration register indexes.
// No dependencies.
package lmlt_pkg;

  // Video modes, encoded as presented on the result stream
  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } video_mode_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_LINE_COMPARE  = 2'd0,
    REG_HBLANK_IRQ_EN = 2'd1,
    REG_OAM_IRQ_EN    = 2'd2,
    REG_CMP_IRQ_EN    = 2'd3
  } cfg_reg_t;

  localparam int unsigned ACC_W  = 16;
  localparam int unsigned LINE_W = 8;

  // Mode durations in machine cycles
  localparam logic [ACC_W-1:0] OAM_CYCLES    = 16'd80;
  localparam logic [ACC_W-1:0] XFER_CYCLES   = 16'd173;
  localparam logic [ACC_W-1:0] HBLANK_CYCLES = 16'd204;
  localparam logic [ACC_W-1:0] LINE_CYCLES   = 16'd456;

  localparam logic [LINE_W-1:0] LAST_VISIBLE_LINE = 8'd143;
  localparam logic [LINE_W-1:0] FIRST_VBLANK_LINE = 8'd144;
  localparam logic [LINE_W-1:0] LAST_LINE         = 8'd153;

  // Result tdata bit positions
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned OB_LINE    = 2;
  localparam int unsigned OB_COIN    = 10;
  localparam int unsigned OB_VBL     = 11;
  localparam int unsigned OB_STAT    = 12;
  localparam int unsigned OB_RENDER  = 13;
  localparam int unsigned OB_RLINE   = 14;

endpackage

>>> hw/rtl/lcd_mode_line_timing_core.sv
// Top level of the LCD mode/line timing core: cycle accumulator, mode
// sequencer, line counter and result register.
// Depends on lmlt_pkg.
//
// channel | dir | handshake             | payload
// --------+-----+-----------------------+-------------------------------------
// in_     | in  | in_tvalid/in_tready   | tdata: tick_cycles; tuser: lcd_on
// out_    | out | out_tvalid/out_tready | tdata: mode..rendered_line; tlast
// cfg_    | in  | cfg_we                | cfg_index, cfg_wdata
//
// One tick per clock while out_ drains: accumulator add, saturation,
// threshold compare and subtract complete in the accept cycle; the result
// appears in the next cycle. The result register is a single stage; a new
// tick is taken whenever it is empty or being drained in the same cycle, so
// stalls on out_ only hold in_tready low while the waiting result is not
// taken. Synchronous active-low reset returns mode to OAM search, line and
// accumulator to 0; clears config, coincidence and valid, but not the data.
module lcd_mode_line_timing_core
  import lmlt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] tick_cycles
  input  logic                  in_tuser,   // [0] lcd_on
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [1:0] video_mode, [9:2] current_line, [10] coincidence, [11] vblank_irq,
  // [12] status_irq, [13] render_line, [21:14] rendered_line, [23:22] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,  // frame_done
  // configuration
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [7:0]            cfg_wdata
);

  // configuration registers
  logic [LINE_W-1:0] line_compare_r;
  logic              hblank_irq_en_r, oam_irq_en_r, cmp_irq_en_r;

  // timing state
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  video_mode_t       mode_r, mode_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic              coin_r, coin_nxt;

  // result register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_last_r;

  logic              in_xfer;
  logic [ACC_W:0]    sum;
  logic [ACC_W-1:0]  acc_sat;
  logic              fire;
  logic              coin_match;
  logic [LINE_W-1:0] line_inc;
  logic              vbl_irq, stat_irq, render, done;
  logic [LINE_W-1:0] rline;

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_compare_r  <= '0;
      hblank_irq_en_r <= 1'b0;
      oam_irq_en_r    <= 1'b0;
      cmp_irq_en_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LINE_COMPARE:  line_compare_r  <= cfg_wdata;
        REG_HBLANK_IRQ_EN: hblank_irq_en_r <= cfg_wdata[0];
        REG_OAM_IRQ_EN:    oam_irq_en_r    <= cfg_wdata[0];
        REG_CMP_IRQ_EN:    cmp_irq_en_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // saturating accumulate and threshold test for the current mode
  assign sum        = {1'b0, acc_r} + {{(ACC_W+1-8){1'b0}}, in_tdata};
  assign acc_sat    = sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
  assign coin_match = (line_r == line_compare_r);
  assign line_inc   = (line_r >= LAST_LINE) ? '0 : line_r + 8'd1;

  always_comb begin
    unique case (mode_r)
      MODE_HBLANK: fire = (acc_sat >= HBLANK_CYCLES);
      MODE_VBLANK: fire = (acc_sat >= LINE_CYCLES);
      MODE_OAM:    fire = (acc_sat >= OAM_CYCLES);
      MODE_XFER:   fire = (acc_sat >= XFER_CYCLES);
      default:     fire = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    acc_nxt  = acc_r;
    mode_nxt = mode_r;
    line_nxt = line_r;
    coin_nxt = coin_r;
    if (in_tuser) begin
      acc_nxt = acc_sat;
      if (fire) begin
        unique case (mode_r)
          MODE_HBLANK: begin
            acc_nxt  = acc_sat - HBLANK_CYCLES;
            mode_nxt = (line_r == LAST_VISIBLE_LINE) ? MODE_VBLANK : MODE_OAM;
            line_nxt = line_inc;
          end
          MODE_VBLANK: begin
            acc_nxt  = acc_sat - LINE_CYCLES;
            if (line_r == LAST_LINE) mode_nxt = MODE_OAM;
            line_nxt = line_inc;
          end
          MODE_OAM: begin
            acc_nxt  = acc_sat - OAM_CYCLES;
            coin_nxt = coin_match;
            mode_nxt = MODE_XFER;
          end
          MODE_XFER: begin
            acc_nxt  = acc_sat - XFER_CYCLES;
            mode_nxt = MODE_HBLANK;
          end
          default: ;
        endcase
      end
    end
  end

  // per-tick strobes and interrupt requests
  always_comb begin
    vbl_irq  = 1'b0;
    stat_irq = 1'b0;
    render   = 1'b0;
    rline    = '0;
    done     = 1'b0;
    if (in_tuser && fire) begin
      unique case (mode_r)
        MODE_HBLANK: begin
          render   = 1'b1;
          rline    = line_r;
          stat_irq = hblank_irq_en_r;
        end
        MODE_VBLANK: begin
          vbl_irq = (line_r == FIRST_VBLANK_LINE);
          done    = (line_r == LAST_LINE);
        end
        MODE_OAM: stat_irq = oam_irq_en_r || (coin_match && cmp_irq_en_r);
        MODE_XFER: ;
        default: ;
      endcase
    end
  end

  // state update on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      mode_r <= MODE_OAM;
      line_r <= '0;
      coin_r <= 1'b0;
    end else if (in_xfer) begin
      acc_r  <= acc_nxt;
      mode_r <= mode_nxt;
      line_r <= line_nxt;
      coin_r <= coin_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r <= {2'b00, rline, render, stat_irq, vbl_irq, coin_nxt, line_nxt,
                     mode_nxt};
      out_last_r <= done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

>>> hw/rtl/lcd_mode_line_timing_checker.sv
// Port-level checker for lcd_mode_line_timing_core, bound to the top level.
// Depends on lmlt_pkg.
module lcd_mode_line_timing_checker
  import lmlt_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // every input transfer produces a result
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("input transfer without result");

  // rendered_line is zero unless render_line is set
  a_rline_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[OB_RENDER] |-> out_tdata[OB_RLINE +: LINE_W] == '0)
    else $error("rendered_line set without render strobe");

  // frame done returns to line 0 in OAM search
  a_frame_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |->
      out_tdata[OB_LINE +: LINE_W] == '0 && out_tdata[1:0] == MODE_OAM)
    else $error("frame done not at line 0 / OAM search");

  // vblank interrupt leaves the controller in vblank on the following line
  a_vblank_irq: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OB_VBL] |->
      out_tdata[1:0] == MODE_VBLANK &&
      out_tdata[OB_LINE +: LINE_W] == FIRST_VBLANK_LINE + 8'd1)
    else $error("vblank interrupt outside vblank start");

endmodule

bind lcd_mode_line_timing_core lcd_mode_line_timing_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

>>> sim/testbench.sv
// Self-checking testbench for lcd_mode_line_timing_core: random tick streams
// with stalls on both sides, checked against a behavioral mode/line predictor.
// Depends on lmlt_pkg and the core RTL.
`timescale 1ns / 100ps

import lmlt_pkg::*;

// One expected result transfer
typedef struct {
  video_mode_t       mode;
  logic [LINE_W-1:0] line;
  bit                coin;
  bit                vbl;
  bit                stat;
  bit                render;
  logic [LINE_W-1:0] rline;
  bit                done;
} line_timing_t;

// Mode sequencer predictor plus the queue of results still owed by the core
class lcd_timing_scoreboard;
  line_timing_t      timing_q[$];
  // register mirror
  logic [LINE_W-1:0] cmp_line;
  bit                hbl_en;
  bit                oam_en;
  bit                cmp_en;
  // sequencer state
  logic [ACC_W-1:0]  acc;
  video_mode_t       mode;
  logic [LINE_W-1:0] line;
  bit                coin;
  int                errors;
  int                sat_hits;

  function new();
    cmp_line = '0;
    hbl_en   = 1'b0;
    oam_en   = 1'b0;
    cmp_en   = 1'b0;
    acc      = '0;
    mode     = MODE_OAM;
    line     = '0;
    coin     = 1'b0;
    errors   = 0;
    sat_hits = 0;
  endfunction

  function int pending();
    return timing_q.size();
  endfunction

  function void set_reg(cfg_reg_t idx, logic [7:0] val);
    case (idx)
      REG_LINE_COMPARE:  cmp_line = val;
      REG_HBLANK_IRQ_EN: hbl_en   = val[0];
      REG_OAM_IRQ_EN:    oam_en   = val[0];
      default:           cmp_en   = val[0];
    endcase
  endfunction

  function logic [LINE_W-1:0] step_line(logic [LINE_W-1:0] cur);
    return (cur >= LAST_LINE) ? '0 : cur + 8'd1;
  endfunction

  // Advance the sequencer by one accepted tick and queue its result
  function void note_tick(logic [7:0] cycles, bit on);
    logic [ACC_W:0] sum;
    line_timing_t   r;
    r.vbl    = 1'b0;
    r.stat   = 1'b0;
    r.render = 1'b0;
    r.rline  = '0;
    r.done   = 1'b0;
    if (on) begin
      sum = {1'b0, acc} + {9'd0, cycles};
      if (sum[ACC_W]) begin
        acc = '1;
        sat_hits++;
      end else begin
        acc = sum[ACC_W-1:0];
      end
      // at most one transition per tick; leftover cycles stay in acc
      case (mode)
        MODE_HBLANK: if (acc >= HBLANK_CYCLES) begin
          acc      = acc - HBLANK_CYCLES;
          r.render = 1'b1;
          r.rline  = line;
          r.stat   = hbl_en;
          if (line == LAST_VISIBLE_LINE) mode = MODE_VBLANK;
          else mode = MODE_OAM;
          line = step_line(line);
        end
        MODE_VBLANK: if (acc >= LINE_CYCLES) begin
          acc   = acc - LINE_CYCLES;
          r.vbl = (line == FIRST_VBLANK_LINE);
          if (line == LAST_LINE) begin
            r.done = 1'b1;
            mode   = MODE_OAM;
          end
          line = step_line(line);
        end
        MODE_OAM: if (acc >= OAM_CYCLES) begin
          acc    = acc - OAM_CYCLES;
          coin   = (line == cmp_line);
          r.stat = oam_en || (coin && cmp_en);
          mode   = MODE_XFER;
        end
        default: if (acc >= XFER_CYCLES) begin
          acc  = acc - XFER_CYCLES;
          mode = MODE_HBLANK;
        end
      endcase
    end
    r.mode = mode;
    r.line = line;
    r.coin = coin;
    timing_q.push_back(r);
  endfunction

  task report_mismatch(string field, int got, int want);
    errors++;
    if (errors <= 20)
      $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, field, got, want);
  endtask

  // Compare one result transfer with the oldest expectation
  task check_result(logic [OUT_DATA_W-1:0] d, bit last);
    line_timing_t want;
    if (timing_q.size() == 0) begin
      report_mismatch("result with nothing pending, tdata", int'(d), 0);
      return;
    end
    want = timing_q.pop_front();
    if (d[OB_LINE-1:0] != want.mode)
      report_mismatch("video_mode", d[OB_LINE-1:0], want.mode);
    if (d[OB_LINE +: LINE_W] != want.line)
      report_mismatch("current_line", d[OB_LINE +: LINE_W], want.line);
    if (d[OB_COIN] != want.coin)
      report_mismatch("coincidence", d[OB_COIN], want.coin);
    if (d[OB_VBL] != want.vbl)
      report_mismatch("vblank_irq", d[OB_VBL], want.vbl);
    if (d[OB_STAT] != want.stat)
      report_mismatch("status_irq", d[OB_STAT], want.stat);
    if (d[OB_RENDER] != want.render)
      report_mismatch("render_line", d[OB_RENDER], want.render);
    if (d[OB_RLINE +: LINE_W] != want.rline)
      report_mismatch("rendered_line", d[OB_RLINE +: LINE_W], want.rline);
    if (d[OUT_DATA_W-1:OB_RLINE+LINE_W] != '0)
      report_mismatch("tdata padding", d[OUT_DATA_W-1:OB_RLINE+LINE_W], 0);
    if (last != want.done)
      report_mismatch("frame_done", last, want.done);
  endtask
endclass

module testbench;

  localparam int WATCHDOG_LIMIT = 2000;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_we     = 1'b0;
  logic [1:0]            cfg_index  = '0;
  logic [7:0]            cfg_wdata  = '0;

  int                    idle_cycles = 0;
  lcd_timing_scoreboard  sb = new();

  always #1 clk = ~clk;

  lcd_mode_line_timing_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
  end

  // Watchdog: too long without any transfer ends the run
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("** lcd_mode_line_timing_core: FAILED **");
        $finish;
      end
    end
  end

  // Receiver back-pressure: a new randomly chosen pattern for each random span
  initial begin : result_sink
    int style;
    int span;
    forever begin
      style = $urandom_range(0, 4);
      span  = $urandom_range(8, 64);
      for (int k = 0; k < span; k++) begin
        @(negedge clk);
        case (style)
          1:       out_tready <= 1'($urandom_range(0, 1));
          2:       out_tready <= (k % 3 == 0);
          3:       out_tready <= 1'b0;
          default: out_tready <= 1'b1;
        endcase
      end
    end
  end

  // One tick transfer; returns after the accepting edge
  task automatic send_tick(input logic [7:0] cycles, input bit on);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= cycles;
    in_tuser  <= on;
    do @(posedge clk); while (!in_tready);
    sb.note_tick(cycles, on);
  endtask

  task automatic idle_input(input int n);
    @(negedge clk);
    in_tvalid <= 1'b0;
    in_tdata  <= 8'($urandom_range(0, 255));
    in_tuser  <= 1'($urandom_range(0, 1));
    repeat (n - 1) @(negedge clk);
  endtask

  // Hold off the sender until every owed result has been taken
  task automatic wait_idle();
    idle_input(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write all four registers back to back; only called while idle
  task automatic program_regs(input logic [7:0] lc, input logic [7:0] hb,
                              input logic [7:0] oam, input logic [7:0] cmp);
    cfg_reg_t   idx [4];
    logic [7:0] val [4];
    idx = '{REG_LINE_COMPARE, REG_HBLANK_IRQ_EN, REG_OAM_IRQ_EN, REG_CMP_IRQ_EN};
    val = '{lc, hb, oam, cmp};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
      sb.set_reg(idx[i], val[i]);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Bursts of ticks with random gaps; display-off ticks are not counted
  task automatic run_ticks(input int count, input int style, input int off_pct);
    int         sent;
    int         burst;
    logic [7:0] cyc;
    bit         on;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < count; k++) begin
        case (style)
          0:       cyc = 8'($urandom_range(0, 255));
          1:       cyc = 8'($urandom_range(150, 255));
          2:       cyc = 8'($urandom_range(0, 40));
          3:       cyc = $urandom_range(0, 1) ? 8'd255 : 8'd0;
          default: cyc = 8'd255;
        endcase
        on = ($urandom_range(0, 99) >= off_pct);
        send_tick(cyc, on);
        if (on) sent++;
      end
      if ($urandom_range(0, 2) != 0) idle_input($urandom_range(1, 6));
    end
  endtask

  initial begin : stimulus
    int         style;
    int         guard;
    logic [7:0] lc;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: exact thresholds, display off, excess cycles carried over
    send_tick(8'd0, 1'b1);
    send_tick(8'd255, 1'b0);
    send_tick(8'd79, 1'b1);
    send_tick(8'd1, 1'b1);
    send_tick(8'd172, 1'b1);
    send_tick(8'd1, 1'b1);
    send_tick(8'd203, 1'b1);
    send_tick(8'd1, 1'b1);
    send_tick(8'd255, 1'b1);
    send_tick(8'd0, 1'b1);
    wait_idle();
    // enable bytes with upper bits set: only bit 0 counts
    program_regs(8'd2, 8'h01, 8'hFE, 8'hFF);
    repeat (12) send_tick(8'd255, 1'b1);
    wait_idle();

    // Random phases, each with its own register setting
    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       lc = 8'd0;
        1:       lc = 8'd255;
        2:       lc = LAST_LINE;
        3:       lc = FIRST_VBLANK_LINE;
        4:       lc = LAST_VISIBLE_LINE;
        default: lc = 8'($urandom_range(0, 153));
      endcase
      if (p == 0)
        program_regs(lc, 8'hFF, 8'hFF, 8'hFF);
      else if (p == 1)
        program_regs(lc, 8'h00, 8'h00, 8'h00);
      else
        program_regs(lc, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
      case ($urandom_range(0, 5))
        3:       style = 0;
        4:       style = 2;
        5:       style = 3;
        default: style = 1;
      endcase
      run_ticks(20, style, (p == 2) ? 30 : 5);
      wait_idle();
    end

    // Sustained maximum ticks until the accumulator has saturated a while
    program_regs(8'($urandom_range(0, 153)), 8'h01, 8'h00, 8'h01);
    guard = 0;
    while (sb.sat_hits < 8 && guard < 1600) begin
      run_ticks(20, 4, 5);
      guard += 20;
    end
    wait_idle();
    program_regs(8'($urandom_range(0, 153)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    run_ticks(30, 0, 10);

    // Drain and finish
    idle_input(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** lcd_mode_line_timing_core: PASSED **");
    end else begin
      $display("** lcd_mode_line_timing_core: FAILED **");
    end
    $finish;
  end

endmodule
